// ===== sv/armt_pkg.sv =====
// Package for the address range map table.
// Holds operation and status codes, the controller state type and the
// controller-to-datapath command bundle. No dependencies.
package armt_pkg;

    localparam int DATA_W = 48;
    localparam int FIELD_W = 48;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RES
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic commit;
    } t_cmd;

endpackage

// ===== sv/armt_ctrl.sv =====
// Controller state machine of the address range map table.
// Sequences capture, compare and commit; depends on armt_pkg.
module armt_ctrl
    import armt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   accept;

    assign accept = start && (r_state != S_CMP);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_RES;
            S_RES:   n_state = accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.capture = accept;
        o_cmd.eval    = (r_state == S_CMP);
        o_cmd.commit  = (r_state == S_RES);
        busy          = (r_state == S_CMP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_RES);
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== sv/armt_datapath.sv =====
// Datapath of the address range map table: entry registers kept in age
// order (slot 0 newest), query capture, parallel compare and commit.
// Depends on armt_pkg; driven by armt_ctrl commands.
module armt_datapath
    import armt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDRESS_BITS  = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_op,
    input  logic [FIELD_W-1:0] i_base_address,
    input  logic [FIELD_W-1:0] i_range_length,
    input  logic [DATA_W-1:0]  i_entry_data,
    output logic [DATA_W-1:0]  o_result_data,
    output logic [1:0]         o_status
);

    localparam int N  = TABLE_ENTRIES;
    localparam int AW = ADDRESS_BITS;

    logic [AW-1:0]     r_base [N];
    logic [AW-1:0]     r_len  [N];
    logic [DATA_W-1:0] r_data [N];
    logic [N-1:0]      r_valid;

    logic [1:0]        r_op;
    logic [AW-1:0]     r_q_base;
    logic [AW-1:0]     r_q_len;
    logic [AW:0]       r_q_end;
    logic [DATA_W-1:0] r_q_data;
    logic [N-1:0]      r_hit;

    logic [DATA_W-1:0] r_result_data;
    logic [1:0]        r_status;

    logic [AW-1:0]     in_base;
    logic [AW-1:0]     in_len;
    logic [N-1:0]      hit;
    logic [N-1:0]      sel;
    logic [N-1:0]      ge;
    logic              found;
    logic              do_add;
    logic              do_remove;
    logic [DATA_W-1:0] sel_data;
    logic [DATA_W-1:0] n_result_data;
    logic [1:0]        n_status;

    assign in_base = AW'(i_base_address);
    assign in_len  = AW'(i_range_length);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_q_base <= in_base;
            r_q_len  <= in_len;
            r_q_end  <= {1'b0, in_base} + {1'b0, in_len};
            r_q_data <= i_entry_data;
        end
    end

    always_comb begin
        logic [AW:0] e_end;
        logic        contain;
        logic        exact;
        for (int i = 0; i < N; i++) begin
            e_end   = {1'b0, r_base[i]} + {1'b0, r_len[i]};
            contain = (r_base[i] <= r_q_base) && (r_q_end <= e_end);
            exact   = (r_base[i] == r_q_base) && (r_len[i] == r_q_len);
            hit[i]  = r_valid[i] && (((r_op == OP_FIND) && contain) ||
                                     ((r_op == OP_REMOVE) && exact));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_hit <= hit;
        end
    end

    assign sel       = r_hit & (~r_hit + N'(1));
    assign ge        = ~(sel - N'(1));
    assign found     = |r_hit;
    assign do_add    = i_cmd.commit && (r_op == OP_ADD) && !r_valid[N-1];
    assign do_remove = i_cmd.commit && (r_op == OP_REMOVE) && found;

    always_comb begin
        sel_data = '0;
        for (int i = 0; i < N; i++) begin
            sel_data = sel_data | ({DATA_W{sel[i]}} & r_data[i]);
        end
    end

    always_comb begin
        n_result_data = '0;
        n_status      = ST_MISS;
        case (r_op) inside
            OP_ADD: begin
                n_status = r_valid[N-1] ? ST_FULL : ST_OK;
            end
            OP_REMOVE, OP_FIND: begin
                n_status      = found ? ST_OK : ST_MISS;
                n_result_data = found ? sel_data : '0;
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result_data <= n_result_data;
            r_status      <= n_status;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_entry
        logic [AW-1:0]     up_base;
        logic [AW-1:0]     up_len;
        logic [DATA_W-1:0] up_data;
        logic              up_valid;
        logic [AW-1:0]     dn_base;
        logic [AW-1:0]     dn_len;
        logic [DATA_W-1:0] dn_data;
        logic              dn_valid;

        if (i == 0) begin : g_head
            assign dn_base  = r_q_base;
            assign dn_len   = r_q_len;
            assign dn_data  = r_q_data;
            assign dn_valid = 1'b1;
        end else begin : g_body
            assign dn_base  = r_base[i-1];
            assign dn_len   = r_len[i-1];
            assign dn_data  = r_data[i-1];
            assign dn_valid = r_valid[i-1];
        end

        if (i == N - 1) begin : g_tail
            assign up_base  = r_base[i];
            assign up_len   = r_len[i];
            assign up_data  = r_data[i];
            assign up_valid = 1'b0;
        end else begin : g_mid
            assign up_base  = r_base[i+1];
            assign up_len   = r_len[i+1];
            assign up_data  = r_data[i+1];
            assign up_valid = r_valid[i+1];
        end

        always_ff @(posedge i_clk) begin
            if (do_add) begin
                r_base[i] <= dn_base;
                r_len[i]  <= dn_len;
                r_data[i] <= dn_data;
            end else if (do_remove && ge[i]) begin
                r_base[i] <= up_base;
                r_len[i]  <= up_len;
                r_data[i] <= up_data;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (do_add) begin
                r_valid[i] <= dn_valid;
            end else if (do_remove && ge[i]) begin
                r_valid[i] <= up_valid;
            end
        end
    end

    assign o_result_data = r_result_data;
    assign o_status      = r_status;

endmodule

// ===== sv/address_range_map_table.sv =====
// Address range map table, top level.
// Joins armt_ctrl and armt_datapath; depends on armt_pkg.
//
// Usage: drive i_op, i_base_address, i_range_length and i_entry_data with
// start high; a transaction is taken at a rising edge where start is high and
// busy is low. Ops: add (insert as newest), remove (newest exact base and
// length match), find (newest entry wholly containing the queried range).
// Each transaction gives one result: o_valid is high for exactly one cycle
// with o_result_data and o_status (ok, full, not found). The receiver cannot
// stall; it must take the result in that cycle.
// The controller steps from the compare state (S_CMP) to the commit state
// (S_RES); o_valid and the result are registered as S_RES ends. The pace is
// set by the compare stage over all entries followed by the priority select
// and table update; busy is high only in the compare state, so the next
// transaction is taken in the same cycle as the table update.
// Reset (i_rst_n low, synchronous) empties the table and idles the controller;
// entries are kept in age order, so no clearing pass is needed.
module address_range_map_table
    import armt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDRESS_BITS  = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [FIELD_W-1:0] i_base_address,
    input  logic [FIELD_W-1:0] i_range_length,
    input  logic [DATA_W-1:0]  i_entry_data,
    output logic               o_valid,
    output logic [DATA_W-1:0]  o_result_data,
    output logic [1:0]         o_status
);

    t_cmd cmd;

    armt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    armt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_base_address (i_base_address),
        .i_range_length (i_range_length),
        .i_entry_data   (i_entry_data),
        .o_result_data  (o_result_data),
        .o_status       (o_status)
    );

endmodule
